// ----- rtl/tccs_pkg.sv -----
`timescale 1ns / 1ps

package tccs_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int CMD_W  = 3;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CELL_W = ATTR_W + CHAR_W;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [ATTR_W-1:0] t_attr;
    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_cmd CMD_PUT   = t_cmd'(0);
    localparam t_cmd CMD_BACK  = t_cmd'(1);
    localparam t_cmd CMD_CLEAR = t_cmd'(2);
    localparam t_cmd CMD_SET   = t_cmd'(3);
    localparam t_cmd CMD_READ  = t_cmd'(4);

    localparam t_char NEWLINE_CODE = t_char'(8'h0A);
    localparam t_char SPACE_CODE   = t_char'(8'h20);
    localparam t_attr ATTR_RESET   = t_attr'(8'h0F);
    localparam t_attr ATTR_NONE    = t_attr'(8'h00);
    localparam t_cell CELL_RESET   = {ATTR_RESET, SPACE_CODE};
    localparam t_cell CELL_ERASED  = {ATTR_NONE, SPACE_CODE};

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_BLANK,
        ST_FILL,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LATCH,
        DP_EXEC,
        DP_SCROLL,
        DP_BLANK,
        DP_FILL,
        DP_INIT,
        DP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic need_scroll;
        logic scroll_end;
        logic fill_end;
        logic out_busy;
    } t_sts;

endpackage

// ----- rtl/tccs_ram.sv -----
`timescale 1ns / 1ps

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tccs_ctrl.sv -----
`timescale 1ns / 1ps

module tccs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  tccs_pkg::t_sts i_sts,
    output tccs_pkg::t_ctl o_ctl
);

    tccs_pkg::t_state r_state;
    tccs_pkg::t_state n_state;
    logic             can_take;
    logic             accept;

    assign can_take = (r_state == tccs_pkg::ST_IDLE) && !i_sts.out_busy;
    assign accept   = can_take && i_valid;
    assign o_stall  = !can_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccs_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tccs_pkg::ST_INIT: begin
                if (i_sts.fill_end) n_state = tccs_pkg::ST_IDLE;
            end
            tccs_pkg::ST_IDLE: begin
                if (accept) n_state = tccs_pkg::ST_EXEC;
            end
            tccs_pkg::ST_EXEC: begin
                if (i_sts.cmd == tccs_pkg::CMD_CLEAR) begin
                    n_state = tccs_pkg::ST_FILL;
                end else if (i_sts.need_scroll) begin
                    n_state = tccs_pkg::ST_SCROLL;
                end else begin
                    n_state = tccs_pkg::ST_FINISH;
                end
            end
            tccs_pkg::ST_SCROLL: begin
                if (i_sts.scroll_end) n_state = tccs_pkg::ST_BLANK;
            end
            tccs_pkg::ST_BLANK: begin
                if (i_sts.fill_end) n_state = tccs_pkg::ST_FINISH;
            end
            tccs_pkg::ST_FILL: begin
                if (i_sts.fill_end) n_state = tccs_pkg::ST_FINISH;
            end
            tccs_pkg::ST_FINISH: begin
                n_state = tccs_pkg::ST_IDLE;
            end
            default: begin
                n_state = tccs_pkg::ST_INIT;
            end
        endcase
    end

    always_comb begin
        o_ctl.op = tccs_pkg::DP_NOP;
        case (r_state)
            tccs_pkg::ST_INIT:   o_ctl.op = tccs_pkg::DP_INIT;
            tccs_pkg::ST_IDLE:   o_ctl.op = accept ? tccs_pkg::DP_LATCH : tccs_pkg::DP_NOP;
            tccs_pkg::ST_EXEC:   o_ctl.op = tccs_pkg::DP_EXEC;
            tccs_pkg::ST_SCROLL: o_ctl.op = tccs_pkg::DP_SCROLL;
            tccs_pkg::ST_BLANK:  o_ctl.op = tccs_pkg::DP_BLANK;
            tccs_pkg::ST_FILL:   o_ctl.op = tccs_pkg::DP_FILL;
            tccs_pkg::ST_FINISH: o_ctl.op = tccs_pkg::DP_FINISH;
            default:             o_ctl.op = tccs_pkg::DP_NOP;
        endcase
    end

endmodule

// ----- rtl/tccs_dp.sv -----
`timescale 1ns / 1ps

module tccs_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tccs_pkg::t_ctl  i_ctl,
    output tccs_pkg::t_sts  o_sts,
    input  tccs_pkg::t_cmd  i_command,
    input  tccs_pkg::t_char i_char_code,
    input  tccs_pkg::t_row  i_target_row,
    input  tccs_pkg::t_col  i_target_col,
    input  logic            i_cfg_valid,
    input  tccs_pkg::t_attr i_text_attribute,
    input  logic            i_stall,
    output logic            o_valid,
    output tccs_pkg::t_row  o_cur_row,
    output tccs_pkg::t_col  o_cur_col,
    output tccs_pkg::t_pos  o_cursor_position,
    output tccs_pkg::t_cell o_cell_data
);

    tccs_pkg::t_attr r_attr,     n_attr;
    tccs_pkg::t_row  r_row,      n_row;
    tccs_pkg::t_col  r_col,      n_col;
    tccs_pkg::t_addr r_cnt,      n_cnt;
    tccs_pkg::t_cmd  r_cmd,      n_cmd;
    tccs_pkg::t_char r_code,     n_code;
    tccs_pkg::t_row  r_trow,     n_trow;
    tccs_pkg::t_col  r_tcol,     n_tcol;
    logic            r_out_valid, n_out_valid;
    tccs_pkg::t_row  r_out_row,  n_out_row;
    tccs_pkg::t_col  r_out_col,  n_out_col;
    tccs_pkg::t_pos  r_out_pos,  n_out_pos;
    tccs_pkg::t_cell r_out_data, n_out_data;

    tccs_pkg::t_addr cur_lin;
    tccs_pkg::t_addr tgt_lin;
    tccs_pkg::t_cell blank;
    logic            last_row;
    logic            last_col;
    logic            scroll_end;
    logic            fill_end;

    logic            we;
    tccs_pkg::t_addr waddr;
    tccs_pkg::t_cell wdata;
    tccs_pkg::t_addr raddr;
    tccs_pkg::t_cell rdata;

    assign cur_lin = tccs_pkg::t_addr'(r_row) * tccs_pkg::t_addr'(tccs_pkg::COLUMNS)
                   + tccs_pkg::t_addr'(r_col);
    assign tgt_lin = tccs_pkg::t_addr'(r_trow) * tccs_pkg::t_addr'(tccs_pkg::COLUMNS)
                   + tccs_pkg::t_addr'(r_tcol);
    assign blank      = {r_attr, tccs_pkg::SPACE_CODE};
    assign last_row   = r_row == tccs_pkg::t_row'(tccs_pkg::ROWS - 1);
    assign last_col   = r_col == tccs_pkg::t_col'(tccs_pkg::COLUMNS - 1);
    assign scroll_end = r_cnt == tccs_pkg::t_addr'(tccs_pkg::CELLS - tccs_pkg::COLUMNS);
    assign fill_end   = r_cnt == tccs_pkg::t_addr'(tccs_pkg::CELLS - 1);

    assign o_sts.cmd         = r_cmd;
    assign o_sts.need_scroll = (r_cmd == tccs_pkg::CMD_PUT) && last_row
                             && ((r_code == tccs_pkg::NEWLINE_CODE) || last_col);
    assign o_sts.scroll_end  = scroll_end;
    assign o_sts.fill_end    = fill_end;
    assign o_sts.out_busy    = r_out_valid && i_stall;

    tccs_ram #(
        .WIDTH (tccs_pkg::CELL_W),
        .DEPTH (tccs_pkg::CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_attr      = r_attr;
        n_row       = r_row;
        n_col       = r_col;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_code      = r_code;
        n_trow      = r_trow;
        n_tcol      = r_tcol;
        n_out_valid = r_out_valid;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_pos   = r_out_pos;
        n_out_data  = r_out_data;
        we          = 1'b0;
        waddr       = r_cnt;
        wdata       = blank;
        raddr       = tgt_lin;

        if (i_cfg_valid) n_attr = i_text_attribute;
        if (r_out_valid && !i_stall) n_out_valid = 1'b0;

        case (i_ctl.op)
            tccs_pkg::DP_LATCH: begin
                n_cmd  = i_command;
                n_code = i_char_code;
                n_trow = (i_target_row > tccs_pkg::t_row'(tccs_pkg::ROWS - 1))
                       ? tccs_pkg::t_row'(tccs_pkg::ROWS - 1) : i_target_row;
                n_tcol = (i_target_col > tccs_pkg::t_col'(tccs_pkg::COLUMNS - 1))
                       ? tccs_pkg::t_col'(tccs_pkg::COLUMNS - 1) : i_target_col;
            end
            tccs_pkg::DP_EXEC: begin
                n_cnt = '0;
                case (r_cmd)
                    tccs_pkg::CMD_PUT: begin
                        if (r_code == tccs_pkg::NEWLINE_CODE) begin
                            n_col = '0;
                            if (!last_row) n_row = r_row + tccs_pkg::t_row'(1);
                        end else begin
                            we    = 1'b1;
                            waddr = cur_lin;
                            wdata = {r_attr, r_code};
                            if (last_col) begin
                                n_col = '0;
                                if (!last_row) n_row = r_row + tccs_pkg::t_row'(1);
                            end else begin
                                n_col = r_col + tccs_pkg::t_col'(1);
                            end
                        end
                    end
                    tccs_pkg::CMD_BACK: begin
                        if (r_col != '0) begin
                            n_col = r_col - tccs_pkg::t_col'(1);
                            we    = 1'b1;
                            waddr = cur_lin - tccs_pkg::t_addr'(1);
                            wdata = tccs_pkg::CELL_ERASED;
                        end
                    end
                    tccs_pkg::CMD_CLEAR: begin
                        n_row = '0;
                        n_col = '0;
                    end
                    tccs_pkg::CMD_SET: begin
                        n_row = r_trow;
                        n_col = r_tcol;
                    end
                    default: begin
                    end
                endcase
            end
            tccs_pkg::DP_SCROLL: begin
                // read one row ahead, write the previous cycle's read one row up
                raddr = scroll_end ? r_cnt : r_cnt + tccs_pkg::t_addr'(tccs_pkg::COLUMNS);
                we    = r_cnt != '0;
                waddr = r_cnt - tccs_pkg::t_addr'(1);
                wdata = rdata;
                n_cnt = scroll_end ? r_cnt : r_cnt + tccs_pkg::t_addr'(1);
            end
            tccs_pkg::DP_BLANK, tccs_pkg::DP_FILL: begin
                we    = 1'b1;
                n_cnt = fill_end ? '0 : r_cnt + tccs_pkg::t_addr'(1);
            end
            tccs_pkg::DP_INIT: begin
                we    = 1'b1;
                wdata = tccs_pkg::CELL_RESET;
                n_cnt = fill_end ? '0 : r_cnt + tccs_pkg::t_addr'(1);
            end
            tccs_pkg::DP_FINISH: begin
                n_out_valid = 1'b1;
                n_out_row   = r_row;
                n_out_col   = r_col;
                n_out_pos   = tccs_pkg::t_pos'(cur_lin);
                n_out_data  = (r_cmd == tccs_pkg::CMD_READ) ? rdata : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= tccs_pkg::ATTR_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_attr      <= n_attr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_code     <= n_code;
        r_trow     <= n_trow;
        r_tcol     <= n_tcol;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_pos  <= n_out_pos;
        r_out_data <= n_out_data;
    end

    assign o_valid           = r_out_valid;
    assign o_cur_row         = r_out_row;
    assign o_cur_col         = r_out_col;
    assign o_cursor_position = r_out_pos;
    assign o_cell_data       = r_out_data;

endmodule

// ----- rtl/text_console_cursor_scroll_core.sv -----
`timescale 1ns / 1ps

// Text console engine over an 80x25 store of 16-bit cells (attribute high, character low)
// with a cursor. After reset the block runs a clearing pass that fills every
// cell with 0x0F20; o_stall stays high meanwhile, attribute writes are taken at any time.
// Put character, backspace, set cursor, read cell and unused codes go from transfer to
// result through command capture, cell store access and the result register.
// Clear walks the store one cell a cycle. A put that passes the last row scrolls: a row
// copy through the store's read and write ports, then blanking of the bottom row. One
// command is in work at a time; a new one is taken once the previous result has been
// transferred or is being transferred.
module text_console_cursor_scroll_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  tccs_pkg::t_cmd  i_command,
    input  tccs_pkg::t_char i_char_code,
    input  tccs_pkg::t_row  i_target_row,
    input  tccs_pkg::t_col  i_target_col,
    output logic            o_valid,
    input  logic            i_stall,
    output tccs_pkg::t_row  o_cur_row,
    output tccs_pkg::t_col  o_cur_col,
    output tccs_pkg::t_pos  o_cursor_position,
    output tccs_pkg::t_cell o_cell_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  tccs_pkg::t_attr i_text_attribute
);

    tccs_pkg::t_ctl ctl;
    tccs_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    tccs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    tccs_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_sts             (sts),
        .i_command         (i_command),
        .i_char_code       (i_char_code),
        .i_target_row      (i_target_row),
        .i_target_col      (i_target_col),
        .i_cfg_valid       (i_cfg_valid),
        .i_text_attribute  (i_text_attribute),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_cur_row         (o_cur_row),
        .o_cur_col         (o_cur_col),
        .o_cursor_position (o_cursor_position),
        .o_cell_data       (o_cell_data)
    );

endmodule

// ----- rtl/tccs_checker.sv -----
`timescale 1ns / 1ps

module tccs_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input tccs_pkg::t_row  o_cur_row,
    input tccs_pkg::t_col  o_cur_col,
    input tccs_pkg::t_pos  o_cursor_position,
    input tccs_pkg::t_cell o_cell_data
);

    // clearing pass holds off input right after reset
    assert property (@(posedge i_clk) !i_rst_n |=> o_stall)
        else $error("input not held off after reset");

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cursor_position)
            && $stable(o_cell_data))
        else $error("stalled result changed");

    // no result can appear the cycle right after a transfer in
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_valid)
        else $error("result appeared without execution");

    // linear position matches the reported cursor, inside the screen
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cursor_position
            == tccs_pkg::t_pos'(o_cur_row) * tccs_pkg::t_pos'(tccs_pkg::COLUMNS)
               + tccs_pkg::t_pos'(o_cur_col)
            && o_cur_row <= tccs_pkg::t_row'(tccs_pkg::ROWS - 1)
            && o_cur_col <= tccs_pkg::t_col'(tccs_pkg::COLUMNS - 1))
        else $error("cursor position inconsistent");

endmodule

bind text_console_cursor_scroll_core tccs_checker u_tccs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_cur_row         (o_cur_row),
    .o_cur_col         (o_cur_col),
    .o_cursor_position (o_cursor_position),
    .o_cell_data       (o_cell_data)
);

// ----- test/tb_text_console_cursor_scroll_core.sv -----
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll_core;

    import tccs_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 8_000_000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          PHASE_ITEMS  = 155;

    localparam t_cmd CMD_SPARE_FIRST = t_cmd'(5);
    localparam t_cmd CMD_SPARE_LAST  = t_cmd'(7);

    typedef struct packed {
        t_cmd  command;
        t_char char_code;
        t_row  target_row;
        t_col  target_col;
    } t_console_cmd;

    typedef struct packed {
        t_row  rpt_row;
        t_col  rpt_col;
        t_pos  cursor_position;
        t_cell cell_data;
    } t_cursor_report;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_stall;
    t_cmd  i_command = '0;
    t_char i_char_code = '0;
    t_row  i_target_row = '0;
    t_col  i_target_col = '0;
    logic  o_valid;
    logic  i_stall = 1'b0;
    t_row  o_cur_row;
    t_col  o_cur_col;
    t_pos  o_cursor_position;
    t_cell o_cell_data;
    logic  i_cfg_valid = 1'b0;
    logic  o_cfg_ready;
    t_attr i_text_attribute = '0;

    text_console_cursor_scroll_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_char_code       (i_char_code),
        .i_target_row      (i_target_row),
        .i_target_col      (i_target_col),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_cur_row         (o_cur_row),
        .o_cur_col         (o_cur_col),
        .o_cursor_position (o_cursor_position),
        .o_cell_data       (o_cell_data),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_text_attribute  (i_text_attribute)
    );

    // console model
    t_cell screen_model [CELLS];
    int    cur_row_model;
    int    cur_col_model;
    t_attr text_attr_model;

    t_console_cmd   pending_cmd_q [$];
    t_cursor_report expected_report_q [$];
    t_console_cmd   offered_cmd;

    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          err_count = 0;
    logic        pressure_req = 1'b0;
    logic        hold_used = 1'b0;
    int          hold_left = 0;
    int unsigned cycle_count = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void advance_row_model();
        cur_col_model = 0;
        cur_row_model++;
        if (cur_row_model >= ROWS) begin
            for (int i = 0; i + COLUMNS < CELLS; i++)
                screen_model[i] = screen_model[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen_model[i] = {text_attr_model, SPACE_CODE};
            cur_row_model = ROWS - 1;
        end
    endfunction

    function automatic t_cursor_report apply_console_cmd(input t_console_cmd c);
        t_cursor_report rep;
        int             trow;
        int             tcol;
        rep  = '0;
        trow = (int'(c.target_row) > ROWS - 1) ? ROWS - 1 : int'(c.target_row);
        tcol = (int'(c.target_col) > COLUMNS - 1) ? COLUMNS - 1 : int'(c.target_col);
        case (c.command)
            CMD_PUT: begin
                if (c.char_code == NEWLINE_CODE) begin
                    advance_row_model();
                end else begin
                    screen_model[cur_row_model * COLUMNS + cur_col_model] =
                        {text_attr_model, c.char_code};
                    cur_col_model++;
                    if (cur_col_model >= COLUMNS)
                        advance_row_model();
                end
            end
            CMD_BACK: begin
                if (cur_col_model > 0) begin
                    cur_col_model--;
                    screen_model[cur_row_model * COLUMNS + cur_col_model] = CELL_ERASED;
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_model[i] = {text_attr_model, SPACE_CODE};
                cur_row_model = 0;
                cur_col_model = 0;
            end
            CMD_SET: begin
                cur_row_model = trow;
                cur_col_model = tcol;
            end
            CMD_READ: begin
                rep.cell_data = screen_model[trow * COLUMNS + tcol];
            end
            default: begin
            end
        endcase
        rep.rpt_row         = t_row'(cur_row_model);
        rep.rpt_col         = t_col'(cur_col_model);
        rep.cursor_position = t_pos'(cur_row_model * COLUMNS + cur_col_model);
        return rep;
    endfunction

    function automatic t_console_cmd make_cmd(input t_cmd cmd, input t_char ch,
                                              input t_row row, input t_col col);
        t_console_cmd c;
        c.command    = cmd;
        c.char_code  = ch;
        c.target_row = row;
        c.target_col = col;
        return c;
    endfunction

    function automatic t_console_cmd random_console_cmd();
        t_console_cmd c;
        int           pick;
        c    = make_cmd(CMD_PUT, t_char'($urandom), t_row'($urandom), t_col'($urandom));
        pick = $urandom_range(99);
        if ($urandom_range(3) != 0) begin
            c.target_row = t_row'($urandom_range(ROWS - 1));
            c.target_col = t_col'($urandom_range(COLUMNS - 1));
        end
        if (pick < 50) begin
            c.command = CMD_PUT;
            if ($urandom_range(7) == 0)
                c.char_code = NEWLINE_CODE;
        end else if (pick < 60) begin
            c.command = CMD_BACK;
        end else if (pick < 62) begin
            c.command = CMD_CLEAR;
        end else if (pick < 76) begin
            c.command = CMD_SET;
        end else if (pick < 95) begin
            c.command = CMD_READ;
        end else begin
            c.command = t_cmd'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        end
        return c;
    endfunction

    task automatic compare_field(input string field_name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            err_count++;
            if (err_count <= 50)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field_name, want, got);
        end
    endtask

    task automatic wait_console_idle();
        do @(negedge i_clk);
        while (pending_cmd_q.size() != 0 || i_valid || expected_report_q.size() != 0);
    endtask

    task automatic write_text_attribute(input t_attr attr);
        @(posedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_text_attribute <= attr;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid     <= 1'b0;
        text_attr_model = attr;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_report_q.push_back(apply_console_cmd(offered_cmd));
            if (!i_valid || !o_stall) begin
                if (pending_cmd_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    offered_cmd = pending_cmd_q.pop_front();
                    i_valid      <= 1'b1;
                    i_command    <= offered_cmd.command;
                    i_char_code  <= offered_cmd.char_code;
                    i_target_row <= offered_cmd.target_row;
                    i_target_col <= offered_cmd.target_col;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cursor_report want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_report_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 50)
                        $display("%0t: unexpected transfer, expected none, actual row %0d col %0d",
                                 $time, o_cur_row, o_cur_col);
                end else begin
                    want = expected_report_q.pop_front();
                    compare_field("row", 16'(want.rpt_row), 16'(o_cur_row));
                    compare_field("col", 16'(want.rpt_col), 16'(o_cur_col));
                    compare_field("cursor_position", 16'(want.cursor_position),
                                  16'(o_cursor_position));
                    compare_field("cell_data", want.cell_data, o_cell_data);
                end
            end
            i_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (pressure_req && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int queued;
        int line_len;
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = CELL_RESET;
        cur_row_model   = 0;
        cur_col_model   = 0;
        text_attr_model = ATTR_RESET;

        // directed part at the reset attribute
        pending_cmd_q.push_back(make_cmd(CMD_READ, 8'h00, 5'd0, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_READ, 8'hFF, 5'd31, 7'd127));
        pending_cmd_q.push_back(make_cmd(CMD_BACK, 8'h00, 5'd0, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_PUT, 8'h41, 5'd0, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_PUT, 8'hFF, 5'd31, 7'd127));
        pending_cmd_q.push_back(make_cmd(CMD_PUT, 8'h00, 5'd0, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_BACK, 8'hFF, 5'd31, 7'd127));
        pending_cmd_q.push_back(make_cmd(CMD_READ, 8'h00, 5'd0, 7'd2));
        pending_cmd_q.push_back(make_cmd(CMD_READ, 8'h00, 5'd0, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_SET, 8'h00, 5'd24, 7'd79));
        pending_cmd_q.push_back(make_cmd(CMD_PUT, 8'h5A, 5'd0, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_READ, 8'h00, 5'd23, 7'd79));
        pending_cmd_q.push_back(make_cmd(CMD_READ, 8'h00, 5'd24, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_READ, 8'h00, 5'd22, 7'd79));
        pending_cmd_q.push_back(make_cmd(CMD_SET, 8'hFF, 5'd31, 7'd127));
        pending_cmd_q.push_back(make_cmd(CMD_BACK, 8'h00, 5'd0, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_READ, 8'h00, 5'd24, 7'd78));
        pending_cmd_q.push_back(make_cmd(CMD_SET, 8'h00, 5'd0, 7'd79));
        pending_cmd_q.push_back(make_cmd(CMD_PUT, 8'h78, 5'd0, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_SPARE_FIRST, 8'hFF, 5'd31, 7'd127));
        pending_cmd_q.push_back(make_cmd(CMD_SPARE_LAST, 8'h00, 5'd0, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_CLEAR, 8'h00, 5'd0, 7'd0));
        pending_cmd_q.push_back(make_cmd(CMD_READ, 8'h00, 5'd12, 7'd40));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_console_idle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_text_attribute(8'h00);
                1: write_text_attribute(8'hFF);
                3: write_text_attribute(8'hA5);
                5: write_text_attribute(8'h5A);
                default: write_text_attribute(t_attr'($urandom));
            endcase
            @(negedge i_clk);
            case (phase)
                1: begin
                    sender_idle_pct    = 59;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 59;
                end
                3, 5: begin
                    sender_idle_pct    = 34;
                    receiver_stall_pct = 34;
                end
                default: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            if (phase == 4)
                pressure_req = 1'b1;
            queued = 0;
            while (queued < PHASE_ITEMS) begin
                if ($urandom_range(99) < 20) begin
                    // a line of printable text
                    line_len = $urandom_range(40, 1);
                    for (int k = 0; k < line_len; k++)
                        pending_cmd_q.push_back(make_cmd(CMD_PUT,
                            t_char'($urandom_range(8'h7E, 8'h20)),
                            t_row'($urandom), t_col'($urandom)));
                    pending_cmd_q.push_back(make_cmd(CMD_PUT, NEWLINE_CODE,
                        t_row'($urandom), t_col'($urandom)));
                    queued += line_len + 1;
                end else begin
                    pending_cmd_q.push_back(random_console_cmd());
                    queued++;
                end
            end
            wait_console_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tccs_pkg.sv
rtl/tccs_ram.sv
rtl/tccs_ctrl.sv
rtl/tccs_dp.sv
rtl/text_console_cursor_scroll_core.sv
rtl/tccs_checker.sv
test/tb_text_console_cursor_scroll_core.sv
